>>> rtl/swsh_pkg.sv
`timescale 1ns / 1ps
package swsh_pkg;

    // Quarter-wave sine entry k: sin(pi/2 * k / 2^tb) in Q.fb.
    // Q.30 Taylor series to the 13th power, products truncated, then
    // rounded half up to Q.fb and clamped to 1.0. Evaluated at elaboration.
    function automatic logic [63:0] sine_entry(input int unsigned k,
                                               input int unsigned fb,
                                               input int unsigned tb);
        logic [63:0]        theta;
        logic [63:0]        theta2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        val;
        int unsigned        sh;
        theta  = (64'(k) * 64'd1686629713) >> tb;
        theta2 = (theta * theta) >> 30;
        term   = theta;
        sum    = $signed(theta);
        sh     = 30 - fb;
        for (int unsigned n = 1; n <= 6; n++) begin
            term = ((term * theta2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        val = $unsigned(sum);
        if (sh > 0) begin
            val = (val + (64'd1 << (sh - 1))) >> sh;
        end
        if (val > (64'd1 << fb)) begin
            val = 64'd1 << fb;
        end
        return val;
    endfunction

endpackage

>>> rtl/swsh_sqrt_pipe.sv
`timescale 1ns / 1ps
module swsh_sqrt_pipe
    import swsh_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic                       in_neg,
    input  logic [2*SAMPLE_BITS-3:0]   in_rad,
    output logic                       out_valid,
    output logic                       out_neg,
    output logic [SAMPLE_BITS-2:0]     out_root
);

    localparam int VW = 2 * SAMPLE_BITS - 2;
    localparam int RW = SAMPLE_BITS - 1;

    // Stage i holds root bits RW-1 down to RW-i resolved.
    logic          valid_reg [1:RW];
    logic          neg_reg   [1:RW];
    logic [VW-1:0] rem_reg   [1:RW];
    logic [RW-1:0] root_reg  [1:RW];

    // One root bit per stage: subtract trial (2*root + 2^b) * 2^b if it fits
    for (genvar i = 1; i <= RW; i++) begin : g_stage
        localparam int B = RW - i;
        logic          prev_valid;
        logic          prev_neg;
        logic [VW-1:0] prev_rem;
        logic [RW-1:0] prev_root;
        logic [VW-1:0] trial;
        logic          fits;

        // First stage takes the input, the others the stage before
        if (i == 1) begin : g_head
            assign prev_valid = in_valid;
            assign prev_neg   = in_neg;
            assign prev_rem   = in_rad;
            assign prev_root  = '0;
        end else begin : g_link
            assign prev_valid = valid_reg[i-1];
            assign prev_neg   = neg_reg[i-1];
            assign prev_rem   = rem_reg[i-1];
            assign prev_root  = root_reg[i-1];
        end

        assign trial = (VW'(prev_root) << (B + 1)) | (VW'(1) << (2 * B));
        assign fits  = prev_rem >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= prev_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                neg_reg[i]  <= prev_neg;
                rem_reg[i]  <= fits ? (prev_rem - trial) : prev_rem;
                root_reg[i] <= prev_root | (fits ? (RW'(1) << B) : '0);
            end
        end
    end

    assign out_valid = valid_reg[RW];
    assign out_neg   = neg_reg[RW];
    assign out_root  = root_reg[RW];

endmodule

>>> rtl/sine_sqrt_waveshaper_unit.sv
`timescale 1ns / 1ps
// Sine waveshaper with square-root compression, fully pipelined.
// Stages: one per root bit in the square-root pipe, then gain multiply,
// fold, sine ROM, interpolate, then clamp and restore sign.
// Throughput: one transaction per cycle; the whole pipe holds on output stall.
// Reset (aresetn low, synchronous) empties the pipe and sets drive_gain to 40.
module sine_sqrt_waveshaper_unit
    import swsh_pkg::*;
#(
    parameter int SAMPLE_BITS     = 24,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [7:0]                         cfg_wr_data,   // drive_gain
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,  // sample_in
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_axis_tdata   // shaped_out
);

    localparam int SB  = SAMPLE_BITS;
    localparam int F   = SAMPLE_BITS - 2;
    localparam int T   = SINE_TABLE_BITS;
    localparam int DW  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int VW  = 2 * SAMPLE_BITS - 2;
    localparam int RW  = SAMPLE_BITS - 1;
    localparam int SEG = 32 - SINE_TABLE_BITS;
    localparam int NE  = (1 << SINE_TABLE_BITS) + 1;

    logic       en;
    logic [7:0] drive_gain_reg;

    // Gain register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_gain_reg <= 8'd40;
        end else if (cfg_wr_en) begin
            drive_gain_reg <= cfg_wr_data;
        end
    end

    // Whole pipe advances when the output slot is free or being taken
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Magnitude and radicand (|x| + 1/4) * 2^F
    logic [SB-1:0] x_in;
    logic          x_neg;
    logic [SB-1:0] x_mag;
    logic [SB-1:0] x_t;
    logic [VW-1:0] x_rad;
    assign x_in  = s_axis_tdata[SB-1:0];
    assign x_neg = x_in[SB-1];
    assign x_mag = x_neg ? (~x_in + SB'(1)) : x_in;
    assign x_t   = x_mag + (SB'(1) << (F - 2));
    assign x_rad = VW'(x_t) << F;

    logic          q_valid;
    logic          q_neg;
    logic [RW-1:0] q_root;

    swsh_sqrt_pipe #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_neg    (x_neg),
        .in_rad    (x_rad),
        .out_valid (q_valid),
        .out_neg   (q_neg),
        .out_root  (q_root)
    );

    // Stage A: phase = gain * (root - 1/2), modulo 2 (pi units)
    logic [RW-1:0]  a_s;
    logic [RW+7:0]  a_prod;
    logic           a_valid_reg;
    logic           a_neg_reg;
    logic [F:0]     a_p_reg;
    assign a_s    = q_root - (RW'(1) << (F - 1));
    assign a_prod = (RW + 8)'(drive_gain_reg) * (RW + 8)'(a_s);

    // Stage B: fold to first quadrant, split into index and fraction
    logic           b_flip;
    logic [F-1:0]   b_p1;
    logic [F-1:0]   b_p2;
    logic [32:0]    b_u;
    logic           b_valid_reg;
    logic           b_neg_reg;
    logic [T:0]     b_idx_reg;
    logic [SEG-1:0] b_frac_reg;
    assign b_flip = a_p_reg[F];
    assign b_p1   = a_p_reg[F-1:0];
    assign b_p2   = (b_p1 > (F'(1) << (F - 1))) ? ((F'(1) << F) - b_p1) : b_p1;
    assign b_u    = 33'(b_p2) << (33 - F);

    // Stage C: sine ROM, two registered reads
    logic [F:0]     sine_rom [0:NE-1];
    for (genvar k = 0; k < NE; k++) begin : g_rom
        localparam logic [63:0] ENTRY = sine_entry(k, F, T);
        assign sine_rom[k] = ENTRY[F:0];
    end

    logic [T:0]     c_addr1;
    logic           c_valid_reg;
    logic           c_neg_reg;
    logic [F:0]     c_e0_reg;
    logic [F:0]     c_e1_reg;
    logic [SEG-1:0] c_frac_reg;
    assign c_addr1 = b_idx_reg[T] ? b_idx_reg : (b_idx_reg + (T + 1)'(1));

    // Stage D: slope times fraction
    logic [F:0]       d_diff;
    logic             d_valid_reg;
    logic             d_neg_reg;
    logic [F:0]       d_e0_reg;
    logic [F+SEG:0]   d_prod_reg;
    assign d_diff = (c_e1_reg < c_e0_reg) ? '0 : (c_e1_reg - c_e0_reg);

    // Stage E: add, clamp, restore sign
    logic [F+1:0]   e_y;
    logic [F:0]     e_yc;
    logic [SB-1:0]  e_out;
    logic           e_valid_reg;
    logic [SB-1:0]  e_data_reg;
    assign e_y   = (F + 2)'(d_e0_reg) + (F + 2)'(d_prod_reg >> SEG);
    assign e_yc  = (e_y > (F + 2)'(1 << F)) ? (F + 1)'(1 << F) : e_y[F:0];
    assign e_out = d_neg_reg ? (SB'(0) - SB'(e_yc)) : SB'(e_yc);

    // Valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= q_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    // Payload stages
    always_ff @(posedge aclk) begin
        if (en) begin
            a_neg_reg  <= q_neg;
            a_p_reg    <= a_prod[F:0];

            b_neg_reg  <= a_neg_reg ^ b_flip;
            b_idx_reg  <= b_u[32:SEG];
            b_frac_reg <= b_u[SEG-1:0];

            c_neg_reg  <= b_neg_reg;
            c_e0_reg   <= sine_rom[b_idx_reg];
            c_e1_reg   <= sine_rom[c_addr1];
            c_frac_reg <= b_frac_reg;

            d_neg_reg  <= c_neg_reg;
            d_e0_reg   <= c_e0_reg;
            d_prod_reg <= (F + SEG + 1)'(d_diff) * (F + SEG + 1)'(c_frac_reg);

            e_data_reg <= e_out;
        end
    end

    assign m_axis_tvalid = e_valid_reg;
    assign m_axis_tdata  = DW'(e_data_reg);

endmodule

>>> verif/sine_sqrt_waveshaper_unit_tb.sv
`timescale 1ns / 1ps
module sine_sqrt_waveshaper_unit_tb;

    localparam int SB        = 24;
    localparam int TB        = 10;
    localparam int FB        = SB - 2;
    localparam int LATENCY   = SB + 4;
    localparam int CYC_LIMIT = 400000;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          cfg_wr_en = 1'b0;
    logic [7:0]    cfg_wr_data = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [23:0]   s_axis_tdata = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [23:0]   m_axis_tdata;

    logic [7:0]    gain_model;
    logic [23:0]   shaped_q[$];
    logic [63:0]   sine_rom[0:(1<<TB)];
    int            err_count = 0;
    int            cycle_count = 0;
    int            hold_cycles = 0;
    bit            stall_en = 1'b1;
    bit            burst_mode = 1'b1;

    always #4 aclk = ~aclk;

    sine_sqrt_waveshaper_unit #(.SAMPLE_BITS(SB), .SINE_TABLE_BITS(TB)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),      // sample_in
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)       // shaped_out
    );

    // Quarter-wave table, Q.30 Taylor series rounded to Q.FB
    function automatic logic [63:0] calc_sine(input logic [63:0] k);
        logic [63:0]        theta, theta2, term, val;
        logic signed [63:0] sum;
        theta  = (k * 64'd1686629713) >> TB;
        theta2 = (theta * theta) >> 30;
        term   = theta;
        sum    = $signed(theta);
        for (int n = 1; n <= 6; n++) begin
            term = ((term * theta2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2) sum = sum - $signed(term);
            else sum = sum + $signed(term);
        end
        if (sum < 0) sum = 0;
        val = $unsigned(sum);
        val = (val + (64'd1 << (30 - FB - 1))) >> (30 - FB);
        if (val > (64'd1 << FB)) val = 64'd1 << FB;
        return val;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [23:0] shape_sample(input logic [23:0] x);
        logic        neg;
        logic [63:0] mag, s, p, u, idx, frac, e0, e1, y, one;
        one  = 64'd1 << FB;
        neg  = x[SB-1];
        mag  = neg ? ((64'd1 << SB) - 64'(x)) : 64'(x);
        s    = int_sqrt((mag + (one >> 2)) << FB) - (one >> 1);
        p    = (64'(gain_model) * s) & ((one << 1) - 1);
        if (p >= one) begin
            neg = ~neg;
            p = p - one;
        end
        if (p > (one >> 1)) p = one - p;
        u    = p << (33 - FB);
        idx  = u >> (32 - TB);
        frac = u & ((64'd1 << (32 - TB)) - 1);
        if (idx >= (64'd1 << TB)) begin
            y = sine_rom[1<<TB];
        end else begin
            e0 = sine_rom[idx];
            e1 = sine_rom[idx + 1];
            if (e1 < e0) e1 = e0;
            y = e0 + (((e1 - e0) * frac) >> (32 - TB));
        end
        if (y > one) y = one;
        return neg ? 24'(64'd0 - y) : y[23:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("MISMATCH %s at cycle %0d: got %h want %h", what, cycle_count, got, want);
        err_count++;
    endtask

    // Cycle counter and run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYC_LIMIT) begin
            $display("sine_sqrt_waveshaper_unit_tb: errors");
            $finish;
        end
    end

    // Receiver: random stall pattern plus long hold-off
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (!stall_en) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (shaped_q.size() == 0) begin
                report_mismatch("unexpected transaction", m_axis_tdata, 24'h0);
            end else begin
                if (m_axis_tdata !== shaped_q[0])
                    report_mismatch("shaped_out", m_axis_tdata, shaped_q[0]);
                void'(shaped_q.pop_front());
            end
        end
    end

    // tvalid stays up after a transaction; a gap or a drain drops it
    task automatic send_sample(input logic [23:0] x);
        if (burst_mode && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        shaped_q.push_back(shape_sample(x));
    endtask

    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        while (shaped_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_gain(input logic [7:0] g);
        drain_pipe();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= g;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        gain_model = g;
        @(posedge aclk);
    endtask

    // Random sample: biased toward small magnitudes and the extremes
    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 4))
            0: return 24'($signed($urandom_range(0, 512)) - 256);
            1: return $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic test_default_gain();
        logic [23:0] pts[10] = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF, 24'h800000,
                                24'h400000, 24'hC00000, 24'h200000, 24'h800001, 24'h555555};
        foreach (pts[i]) send_sample(pts[i]);
        drain_pipe();
    endtask

    task automatic test_gain_extremes();
        logic [7:0] gains[4] = '{8'd0, 8'd255, 8'd1, 8'd128};
        foreach (gains[g]) begin
            write_gain(gains[g]);
            send_sample(24'h000000);
            send_sample(24'h7FFFFF);
            send_sample(24'h800000);
            send_sample(24'h123456);
        end
        drain_pipe();
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        for (int i = 0; i < 60; i++) send_sample(rand_sample());
        drain_pipe();
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 5; ph++) begin
            write_gain(ph == 0 ? 8'd40 : 8'($urandom));
            stall_en   = (ph != 2);
            burst_mode = (ph != 2);
            for (int i = 0; i < 100; i++) send_sample(rand_sample());
        end
        stall_en = 1'b1;
        burst_mode = 1'b1;
        drain_pipe();
    endtask

    initial begin
        for (int k = 0; k <= (1 << TB); k++) sine_rom[k] = calc_sine(64'(k));
        gain_model = 8'd40;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_gain();
        test_gain_extremes();
        test_backpressure();
        test_random();
        if (err_count == 0) begin
            $display("sine_sqrt_waveshaper_unit_tb: clean");
        end else begin
            $display("sine_sqrt_waveshaper_unit_tb: errors");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/swsh_pkg.sv
rtl/swsh_sqrt_pipe.sv
rtl/sine_sqrt_waveshaper_unit.sv
verif/sine_sqrt_waveshaper_unit_tb.sv
